@@ rtl/sha256_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-256 package
// Shared types, round constants and initial hash values for the digest core.
// ----------------------------------------------------------------------------
package sha256_pkg;

   typedef logic [7:0][31:0] hash_type;

   typedef struct packed {
      logic       has_byte;
      logic [7:0] data_byte;
      logic       end_of_message;
   } req_type;

   typedef struct packed {
      logic [31:0] digest_word;
      logic [2:0]  word_index;
      logic        last_word;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ROUND,
      ST_FOLD,
      ST_PAD_MARK,
      ST_PAD_ZERO,
      ST_PAD_LEN,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic       push;
      logic [7:0] push_data;
      logic [5:0] push_slot;
      logic       load_work;
      logic       step;
      logic       fold;
      logic       clear_chain;
      logic [5:0] round_idx;
      logic [2:0] word_idx;
   } ctrl_type;

   localparam logic [7:0] PAD_MARKER = 8'h80;
   localparam logic [5:0] LEN_SLOT   = 6'd56;
   localparam logic [5:0] LAST_SLOT  = 6'd63;
   localparam logic [5:0] LAST_ROUND = 6'd63;
   localparam logic [2:0] LAST_WORD  = 3'd7;

   localparam hash_type INIT_HASH = {
      32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
      32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
   };

   localparam logic [31:0] ROUND_K [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
      rotr = (x >> n) | (x << (32 - n));
   endfunction

endpackage

@@ rtl/sha256_sched.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-256 message window
// Sixteen-word window: filled a byte at a time, then advanced one schedule
// word per round.
// ----------------------------------------------------------------------------
module sha256_sched
   import sha256_pkg::*;
(
   input  logic        clock,
   input  ctrl_type    ctrl,
   output logic [31:0] sched_word
);

   logic [15:0][31:0] win_ff;
   logic [15:0][31:0] win_in;
   logic [31:0]       sig0;
   logic [31:0]       sig1;
   logic [31:0]       new_word;

   always_comb begin
      sig0     = rotr(win_ff[1], 7) ^ rotr(win_ff[1], 18) ^ (win_ff[1] >> 3);
      sig1     = rotr(win_ff[14], 17) ^ rotr(win_ff[14], 19) ^ (win_ff[14] >> 10);
      new_word = win_ff[0] + sig0 + win_ff[9] + sig1;
   end

   always_comb begin
      win_in = win_ff;
      if (ctrl.push) begin
         win_in[ctrl.push_slot[5:2]][{~ctrl.push_slot[1:0], 3'b000} +: 8] = ctrl.push_data;
      end else if (ctrl.step) begin
         win_in = {new_word, win_ff[15:1]};
      end
   end

   always_ff @(posedge clock) begin
      win_ff <= win_in;
   end

   assign sched_word = win_ff[0];

endmodule

@@ rtl/sha256_round.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-256 round unit
// Working variables a..h and the round function, one round per step.
// ----------------------------------------------------------------------------
module sha256_round
   import sha256_pkg::*;
(
   input  logic        clock,
   input  ctrl_type    ctrl,
   input  hash_type    chain,
   input  logic [31:0] sched_word,
   output hash_type    work
);

   hash_type    work_ff;
   hash_type    work_in;
   logic [31:0] big0;
   logic [31:0] big1;
   logic [31:0] ch;
   logic [31:0] maj;
   logic [31:0] t1;

   always_comb begin
      big1 = rotr(work_ff[4], 6) ^ rotr(work_ff[4], 11) ^ rotr(work_ff[4], 25);
      ch   = (work_ff[4] & work_ff[5]) ^ (~work_ff[4] & work_ff[6]);
      t1   = work_ff[7] + big1 + ch + ROUND_K[ctrl.round_idx] + sched_word;
      big0 = rotr(work_ff[0], 2) ^ rotr(work_ff[0], 13) ^ rotr(work_ff[0], 22);
      maj  = (work_ff[0] & work_ff[1]) ^ (work_ff[0] & work_ff[2])
           ^ (work_ff[1] & work_ff[2]);
   end

   always_comb begin
      work_in = work_ff;
      if (ctrl.load_work) begin
         work_in = chain;
      end else if (ctrl.step) begin
         work_in = {work_ff[6:4], work_ff[3] + t1, work_ff[2:0], t1 + big0 + maj};
      end
   end

   always_ff @(posedge clock) begin
      work_ff <= work_in;
   end

   assign work = work_ff;

endmodule

@@ rtl/sha256_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-256 sequencer
// Byte intake, padding, round count and digest output sequencing.
// ----------------------------------------------------------------------------
module sha256_ctrl
   import sha256_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_ready,
   input  req_type  req_payload,
   output logic     rsp_valid,
   input  logic     rsp_ready,
   output ctrl_type ctrl
);

   state_type   state_ff;
   state_type   state_in;
   state_type   resume_ff;
   state_type   resume_in;
   logic [5:0]  fill_ff;
   logic [5:0]  round_ff;
   logic [2:0]  word_ff;
   logic [63:0] total_ff;
   logic [63:0] bit_len;
   logic        req_xfer;
   logic        rsp_xfer;
   logic        wrap;

   assign bit_len  = {total_ff[60:0], 3'b000};
   assign req_xfer = req_valid && req_ready;
   assign rsp_xfer = rsp_valid && rsp_ready;
   assign wrap     = ctrl.push && (fill_ff == LAST_SLOT);

   // outputs
   always_comb begin
      req_ready        = 1'b0;
      rsp_valid        = 1'b0;
      ctrl             = '0;
      ctrl.push_slot   = fill_ff;
      ctrl.round_idx   = round_ff;
      ctrl.word_idx    = word_ff;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready      = 1'b1;
            ctrl.push      = req_valid && req_payload.has_byte;
            ctrl.push_data = req_payload.data_byte;
         end
         ST_ROUND: begin
            ctrl.step = 1'b1;
         end
         ST_FOLD: begin
            ctrl.fold = 1'b1;
         end
         ST_PAD_MARK: begin
            ctrl.push      = 1'b1;
            ctrl.push_data = PAD_MARKER;
         end
         ST_PAD_ZERO: begin
            ctrl.push      = (fill_ff != LEN_SLOT);
            ctrl.push_data = 8'h00;
         end
         ST_PAD_LEN: begin
            ctrl.push      = 1'b1;
            ctrl.push_data = bit_len[{~fill_ff[2:0], 3'b000} +: 8];
         end
         ST_EMIT: begin
            rsp_valid        = 1'b1;
            ctrl.clear_chain = rsp_ready && (word_ff == LAST_WORD);
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
      ctrl.load_work = wrap;
   end

   // next state
   always_comb begin
      state_in  = state_ff;
      resume_in = resume_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               resume_in = req_payload.end_of_message ? ST_PAD_MARK : ST_IDLE;
               state_in  = wrap ? ST_ROUND : resume_in;
            end
         end
         ST_ROUND: begin
            if (round_ff == LAST_ROUND) begin
               state_in = ST_FOLD;
            end
         end
         ST_FOLD: begin
            state_in = resume_ff;
         end
         ST_PAD_MARK: begin
            resume_in = ST_PAD_ZERO;
            state_in  = wrap ? ST_ROUND : ST_PAD_ZERO;
         end
         ST_PAD_ZERO: begin
            if (fill_ff == LEN_SLOT) begin
               state_in = ST_PAD_LEN;
            end else if (wrap) begin
               resume_in = ST_PAD_ZERO;
               state_in  = ST_ROUND;
            end
         end
         ST_PAD_LEN: begin
            if (wrap) begin
               resume_in = ST_EMIT;
               state_in  = ST_ROUND;
            end
         end
         ST_EMIT: begin
            if (rsp_xfer && (word_ff == LAST_WORD)) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         resume_ff <= ST_IDLE;
         fill_ff   <= '0;
         round_ff  <= '0;
         word_ff   <= '0;
         total_ff  <= '0;
      end else begin
         state_ff  <= state_in;
         resume_ff <= resume_in;
         if (ctrl.push) begin
            fill_ff <= fill_ff + 6'd1;
         end
         round_ff <= (state_ff == ST_ROUND) ? round_ff + 6'd1 : '0;
         if (rsp_xfer) begin
            word_ff <= word_ff + 3'd1;
         end
         if (ctrl.clear_chain) begin
            total_ff <= '0;
         end else if (req_xfer && req_payload.has_byte) begin
            total_ff <= total_ff + 64'd1;
         end
      end
   end

endmodule

@@ rtl/sha256_message_digest_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-256 message digest core
// Byte-serial SHA-256 with padding and a word-serial digest output.
// ----------------------------------------------------------------------------
// A message byte transfers whenever the core is idle, not while it is
// compressing, padding or offering the digest. The byte that completes a
// 64-byte block starts a compression (64 rounds, one per cycle on one
// shared round unit, then the chaining add), during which req_ready stays
// low. The end-of-message transfer starts padding at one byte per cycle
// outside compressions (the 0x80 marker, zeros up to byte 56, eight length
// bytes), with one or two compressions, after which the eight digest words
// are offered on rsp_ one per transfer, index 7 flagged last. The core then
// starts a new message from the initial hash values.
// ----------------------------------------------------------------------------
module sha256_message_digest_core
   import sha256_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_payload,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_payload
);

   ctrl_type    ctrl;
   logic [31:0] sched_word;
   hash_type    work;
   hash_type    chain_ff;
   hash_type    chain_in;

   sha256_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .ctrl        (ctrl)
   );

   sha256_sched u_sched (
      .clock      (clock),
      .ctrl       (ctrl),
      .sched_word (sched_word)
   );

   sha256_round u_round (
      .clock      (clock),
      .ctrl       (ctrl),
      .chain      (chain_ff),
      .sched_word (sched_word),
      .work       (work)
   );

   always_comb begin
      chain_in = chain_ff;
      if (ctrl.clear_chain) begin
         chain_in = INIT_HASH;
      end else if (ctrl.fold) begin
         for (int i = 0; i < 8; i++) begin
            chain_in[i] = chain_ff[i] + work[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         chain_ff <= INIT_HASH;
      end else begin
         chain_ff <= chain_in;
      end
   end

   assign rsp_payload.digest_word = chain_ff[ctrl.word_idx];
   assign rsp_payload.word_index  = ctrl.word_idx;
   assign rsp_payload.last_word   = (ctrl.word_idx == LAST_WORD);

endmodule

@@ rtl/sha256_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-256 port checker
// Port-level properties of the digest core, bound to the top level.
// ----------------------------------------------------------------------------
module sha256_checker
   import sha256_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_ready,
   input req_type req_payload,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_payload
);

   // no intake while the digest is out
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("input ready while digest words pending");

   // hold a stalled result
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("stalled result changed");

   a_last_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_payload.last_word == (rsp_payload.word_index == 3'd7)))
      else $error("last flag does not match word index");

   // advance the word index without gaps
   a_index_step: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_payload.last_word |=>
         rsp_valid && (rsp_payload.word_index ==
                       3'($past(rsp_payload.word_index) + 3'd1)))
      else $error("digest word sequence broken");

   // drop valid after the last transfer
   a_last_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_payload.last_word |=> !rsp_valid)
      else $error("result after last digest word");

endmodule

bind sha256_message_digest_core sha256_checker u_checker (.*);

@@ tb/sha256_message_digest_core_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-256 message digest core testbench
// Feeds messages a byte per transfer, some with the last byte on the end
// mark and some with a bare end mark, and checks every digest word against
// a software hash kept in step with the accepted requests. Short messages
// dominate; lengths near the padding and block edges come up at random.
// ----------------------------------------------------------------------------
module sha256_message_digest_core_tb;
   import sha256_pkg::*;

   class digest_book;
      logic [31:0] round_const[64];
      logic [31:0] start_chain[8];
      logic [31:0] chain[8];
      logic [7:0]  blk[64];
      int unsigned fill;
      logic [63:0] total;
      rsp_type     expected[$];
      int unsigned failures;

      function new();
         round_const = '{
            32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
            32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
            32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
            32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
            32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
            32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
            32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
            32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
            32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
            32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
            32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
            32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
            32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
            32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
            32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
            32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
         };
         start_chain = '{
            32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
            32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
         };
         failures = 0;
         restart();
      endfunction

      function void restart();
         chain = start_chain;
         fill  = 0;
         total = '0;
      endfunction

      function logic [31:0] ror(logic [31:0] x, int unsigned n);
         logic [63:0] twice;
         twice = {x, x} >> n;
         return twice[31:0];
      endfunction

      function void compress();
         logic [31:0] w[64];
         logic [31:0] a, b, c, d, e, f, g, h, t1, t2;
         for (int i = 0; i < 16; i++)
            w[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
         for (int i = 16; i < 64; i++)
            w[i] = w[i-16] + w[i-7]
                 + (ror(w[i-15], 7) ^ ror(w[i-15], 18) ^ (w[i-15] >> 3))
                 + (ror(w[i-2], 17) ^ ror(w[i-2], 19) ^ (w[i-2] >> 10));
         {a, b, c, d} = {chain[0], chain[1], chain[2], chain[3]};
         {e, f, g, h} = {chain[4], chain[5], chain[6], chain[7]};
         for (int i = 0; i < 64; i++) begin
            t1 = h + (ror(e, 6) ^ ror(e, 11) ^ ror(e, 25)) + ((e & f) ^ (~e & g))
               + round_const[i] + w[i];
            t2 = (ror(a, 2) ^ ror(a, 13) ^ ror(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
            h = g;
            g = f;
            f = e;
            e = d + t1;
            d = c;
            c = b;
            b = a;
            a = t1 + t2;
         end
         chain[0] += a;
         chain[1] += b;
         chain[2] += c;
         chain[3] += d;
         chain[4] += e;
         chain[5] += f;
         chain[6] += g;
         chain[7] += h;
      endfunction

      function void absorb(logic [7:0] value);
         blk[fill] = value;
         fill = (fill + 1) % 64;
         if (fill == 0) compress();
      endfunction

      function void note_request(req_type r);
         logic [63:0] bit_len;
         rsp_type     word;
         if (r.has_byte) begin
            absorb(r.data_byte);
            total += 64'd1;
         end
         if (!r.end_of_message) return;
         bit_len = total << 3;
         absorb(PAD_MARKER);
         while (fill != int'(LEN_SLOT)) absorb(8'h00);
         for (int i = 0; i < 8; i++) absorb(bit_len[63 - 8*i -: 8]);
         for (int i = 0; i < 8; i++) begin
            word.digest_word = chain[i];
            word.word_index  = 3'(i);
            word.last_word   = (i == 7);
            expected.push_back(word);
         end
         restart();
      endfunction

      function void check_result(rsp_type got);
         rsp_type want;
         if (expected.size() == 0) begin
            $error("unexpected digest transfer %h", got);
            failures++;
            return;
         end
         want = expected.pop_front();
         if (got.digest_word !== want.digest_word) begin
            $error("digest_word expected %h actual %h", want.digest_word, got.digest_word);
            failures++;
         end
         if (got.word_index !== want.word_index) begin
            $error("word_index expected %0d actual %0d", want.word_index, got.word_index);
            failures++;
         end
         if (got.last_word !== want.last_word) begin
            $error("last_word expected %b actual %b", want.last_word, got.last_word);
            failures++;
         end
      endfunction

      function int pending();
         return expected.size();
      endfunction
   endclass

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_payload = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_payload;

   digest_book  book;
   int unsigned counted_items = 0;
   int unsigned burst_left = 0;
   logic [6:0]  ready_pattern = '1;
   int unsigned pattern_age = 0;

   sha256_message_digest_core u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   task automatic offer(input logic has_byte, input logic [7:0] data_byte,
                        input logic end_of_message);
      req_type r;
      r.has_byte       = has_byte;
      r.data_byte      = data_byte;
      r.end_of_message = end_of_message;
      req_valid   <= 1'b1;
      req_payload <= r;
      do @(posedge clock); while (req_ready !== 1'b1);
      book.note_request(r);
      counted_items++;
      // drop valid for a gap once the burst runs out
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                  : $urandom_range(0, 8);
      end
   endtask

   task automatic send_message(input int unsigned len);
      logic end_with_byte;
      end_with_byte = (len > 0) && ($urandom_range(0, 1) == 1);
      for (int unsigned i = 0; i < len; i++) begin
         if ($urandom_range(0, 9) == 0) offer(1'b0, 8'($urandom), 1'b0);
         offer(1'b1, 8'($urandom), end_with_byte && (i == len - 1));
      end
      if (!end_with_byte) offer(1'b0, 8'($urandom), 1'b1);
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_ready) book.check_result(rsp_payload);
      if (pattern_age == 48) begin
         pattern_age   <= 0;
         ready_pattern <= ($urandom_range(0, 3) == 0) ? 7'h7f : (7'($urandom) | 7'h01);
      end else begin
         pattern_age <= pattern_age + 1;
      end
      rsp_ready <= ready_pattern[pattern_age % 7];
   end

   initial begin
      int unsigned len;
      int unsigned edge_lengths[7];
      edge_lengths = '{55, 56, 63, 64, 65, 119, 120};
      book = new();
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      offer(1'b0, 8'h00, 1'b1);
      offer(1'b1, 8'hff, 1'b1);
      offer(1'b1, 8'h00, 1'b0);
      offer(1'b0, 8'hff, 1'b0);
      offer(1'b0, 8'hff, 1'b1);
      offer(1'b1, 8'h61, 1'b0);
      offer(1'b1, 8'h62, 1'b0);
      offer(1'b1, 8'h63, 1'b1);
      offer(1'b1, 8'hff, 1'b0);
      offer(1'b1, 8'h00, 1'b0);
      offer(1'b0, 8'h00, 1'b1);

      while (counted_items < 150) begin
         if ($urandom_range(0, 4) == 0) len = edge_lengths[$urandom_range(0, 6)];
         else len = $urandom_range(0, 12);
         if (counted_items + len >= 150) len = 150 - counted_items - 1;
         send_message(len);
      end
      req_valid <= 1'b0;

      while (book.pending() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (book.failures == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("CHECK FAILED");
      $finish;
   end

endmodule

@@ sim.f @@
rtl/sha256_pkg.sv
rtl/sha256_sched.sv
rtl/sha256_round.sv
rtl/sha256_ctrl.sv
rtl/sha256_message_digest_core.sv
rtl/sha256_checker.sv
tb/sha256_message_digest_core_tb.sv
